/* hdl/pbwd_pkg.sv */
// Package with the shared types, codes and field decode of the protobuf wire stream decoder.
package pbwd_pkg;

    localparam int unsigned PhaseW = 3;
    localparam int unsigned StatusW = 3;
    localparam int unsigned SelW = 2;
    localparam int unsigned AccumW = 64;
    localparam int unsigned CountW = 4;
    localparam int unsigned FieldNumW = 32;

    localparam logic [PhaseW-1:0] PH_TAG = 3'd0;
    localparam logic [PhaseW-1:0] PH_VAL = 3'd1;
    localparam logic [PhaseW-1:0] PH_LEN = 3'd2;
    localparam logic [PhaseW-1:0] PH_STR = 3'd3;
    localparam logic [PhaseW-1:0] PH_ERR = 3'd4;

    localparam logic [StatusW-1:0] ERR_NONE = 3'd0;
    localparam logic [StatusW-1:0] ERR_TRUNC = 3'd1;
    localparam logic [StatusW-1:0] ERR_LONG = 3'd2;
    localparam logic [StatusW-1:0] ERR_PAST = 3'd3;
    localparam logic [StatusW-1:0] ERR_WIRE = 3'd4;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN = 3'd2;

    localparam logic [CountW-1:0] MaxVarintBytes = 4'd10;

    typedef struct packed {
        logic            data_valid;
        logic [7:0]      data_byte;
        logic [SelW-1:0] field_sel;
        logic            field_clear;
        logic            msg_done;
        logic [StatusW-1:0] msg_status;
    } t_result;

    typedef struct packed {
        logic            kept;
        logic [SelW-1:0] sel;
    } t_slot;

    function automatic t_slot field_slot(input logic [FieldNumW-1:0] fn);
        t_slot s;
        s.kept = 1'b1;
        s.sel = 2'd0;
        case (fn)
            32'd2: s.sel = 2'd0;
            32'd3: s.sel = 2'd1;
            32'd4: s.sel = 2'd2;
            32'd6: s.sel = 2'd3;
            default: s.kept = 1'b0;
        endcase
        return s;
    endfunction

endpackage

/* hdl/pbwd_in_if.sv */
// Interface for the input byte channel.
interface pbwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* hdl/pbwd_out_if.sv */
// Interface for the decoded result channel.
interface pbwd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] field_sel;
    logic       field_clear;
    logic       msg_done;
    logic [2:0] msg_status;

    modport source (
        output valid, output data_valid, output data_byte, output field_sel,
        output field_clear, output msg_done, output msg_status, input ready
    );
    modport sink (
        input valid, input data_valid, input data_byte, input field_sel,
        input field_clear, input msg_done, input msg_status, output ready
    );
endinterface

/* hdl/pbwd_parser.sv */
// Parser state and single-pass next-state logic for one message byte.
module pbwd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output pbwd_pkg::t_result o_result
);

    logic [pbwd_pkg::PhaseW-1:0]  r_phase, n_phase;
    logic [pbwd_pkg::AccumW-1:0]  r_accum, n_accum;
    logic [pbwd_pkg::CountW-1:0]  r_cnt, n_cnt;
    pbwd_pkg::t_slot              r_slot, n_slot;
    logic [pbwd_pkg::AccumW-1:0]  r_left, n_left;
    logic [pbwd_pkg::StatusW-1:0] r_err, n_err;

    logic [6:0]                   w_shift;
    logic [pbwd_pkg::AccumW-1:0]  w_add;
    logic [pbwd_pkg::AccumW-1:0]  w_value;
    logic [pbwd_pkg::CountW-1:0]  w_cnt_inc;
    logic [pbwd_pkg::AccumW-1:0]  w_left_dec;
    pbwd_pkg::t_result            w_res;

    assign w_shift = {r_cnt, 3'b000} - {3'b000, r_cnt};
    assign w_add = {57'd0, i_byte[6:0]} << w_shift[5:0];
    assign w_value = w_shift[6] ? r_accum : (r_accum | w_add);
    assign w_cnt_inc = r_cnt + 4'd1;
    assign w_left_dec = (r_left != '0) ? (r_left - 64'd1) : r_left;

    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_cnt = r_cnt;
        n_slot = r_slot;
        n_left = r_left;
        n_err = r_err;
        w_res = '0;
        if (i_accept) begin
            case (r_phase)
                pbwd_pkg::PH_TAG, pbwd_pkg::PH_VAL, pbwd_pkg::PH_LEN: begin
                    if (i_byte[7]) begin
                        n_accum = w_value;
                        n_cnt = w_cnt_inc;
                        if (w_cnt_inc >= pbwd_pkg::MaxVarintBytes) begin
                            n_err = pbwd_pkg::ERR_LONG;
                            n_phase = pbwd_pkg::PH_ERR;
                        end
                    end else begin
                        n_accum = '0;
                        n_cnt = '0;
                        case (r_phase)
                            pbwd_pkg::PH_TAG: begin
                                n_slot = pbwd_pkg::field_slot(w_value[34:3]);
                                if (w_value[2:0] == pbwd_pkg::WT_VARINT) begin
                                    n_phase = pbwd_pkg::PH_VAL;
                                end else if (w_value[2:0] == pbwd_pkg::WT_LEN) begin
                                    n_phase = pbwd_pkg::PH_LEN;
                                end else begin
                                    n_err = pbwd_pkg::ERR_WIRE;
                                    n_phase = pbwd_pkg::PH_ERR;
                                end
                            end
                            pbwd_pkg::PH_VAL: begin
                                n_phase = pbwd_pkg::PH_TAG;
                            end
                            default: begin
                                n_left = w_value;
                                if (r_slot.kept) begin
                                    w_res.field_clear = 1'b1;
                                    w_res.field_sel = r_slot.sel;
                                end
                                n_phase = (w_value != '0) ? pbwd_pkg::PH_STR
                                                          : pbwd_pkg::PH_TAG;
                            end
                        endcase
                    end
                end
                pbwd_pkg::PH_STR: begin
                    if (r_slot.kept) begin
                        w_res.data_valid = 1'b1;
                        w_res.data_byte = i_byte;
                        w_res.field_sel = r_slot.sel;
                    end
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_phase = pbwd_pkg::PH_TAG;
                    end
                end
                default: begin
                end
            endcase
            if (i_last) begin
                w_res.msg_done = 1'b1;
                if (n_err == pbwd_pkg::ERR_NONE && n_phase != pbwd_pkg::PH_TAG) begin
                    w_res.msg_status = (n_phase == pbwd_pkg::PH_STR) ? pbwd_pkg::ERR_PAST
                                                                    : pbwd_pkg::ERR_TRUNC;
                end else begin
                    w_res.msg_status = n_err;
                end
                n_phase = pbwd_pkg::PH_TAG;
                n_accum = '0;
                n_cnt = '0;
                n_slot = '0;
                n_left = '0;
                n_err = pbwd_pkg::ERR_NONE;
            end
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pbwd_pkg::PH_TAG;
            r_accum <= '0;
            r_cnt <= '0;
            r_slot <= '0;
            r_left <= '0;
            r_err <= pbwd_pkg::ERR_NONE;
        end else begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_cnt <= n_cnt;
            r_slot <= n_slot;
            r_left <= n_left;
            r_err <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbwd_pkg::PH_ERR) |-> (r_err != pbwd_pkg::ERR_NONE))
        else $error("Error phase without an error code.");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pbwd_pkg::PH_ERR) |-> (r_err == pbwd_pkg::ERR_NONE))
        else $error("Error code set outside the error phase.");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_phase == pbwd_pkg::PH_TAG && r_cnt == '0
                                  && r_err == pbwd_pkg::ERR_NONE))
        else $error("Parser state not cleared after the last byte.");
    a_str_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbwd_pkg::PH_STR) |-> (r_left != '0))
        else $error("String phase with no bytes owed.");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pbwd_pkg::PH_ERR) |-> (r_cnt < pbwd_pkg::MaxVarintBytes))
        else $error("Varint byte count out of range.");
`endif

endmodule

/* hdl/pbwd_out_reg.sv */
// Result register that holds one transaction until the sink takes it.
module pbwd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pbwd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output pbwd_pkg::t_result o_result
);

    logic              r_valid;
    pbwd_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/protobuf_wire_stream_decoder_top.sv */
// A result transaction is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; each byte passes once through the parser logic
// into the result register, and a new byte is taken whenever that register is free
// or being read in the same cycle.
// Reset (synchronous, active low) returns the parser to the tag phase and empties
// the result register.
module protobuf_wire_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbwd_in_if.sink     i_in,
    pbwd_out_if.source  o_out
);

    logic              w_can_load;
    logic              w_accept;
    logic              w_valid;
    pbwd_pkg::t_result w_next;
    pbwd_pkg::t_result w_held;

    assign i_in.ready = w_can_load;
    assign w_accept = i_in.valid && w_can_load;

    pbwd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .o_result (w_next)
    );

    pbwd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_next),
        .i_ready    (o_out.ready),
        .o_can_load (w_can_load),
        .o_valid    (w_valid),
        .o_result   (w_held)
    );

    assign o_out.valid = w_valid;
    assign o_out.data_valid = w_held.data_valid;
    assign o_out.data_byte = w_held.data_byte;
    assign o_out.field_sel = w_held.field_sel;
    assign o_out.field_clear = w_held.field_clear;
    assign o_out.msg_done = w_held.msg_done;
    assign o_out.msg_status = w_held.msg_status;

endmodule
